[hw/rtl/depth_pixel_back_projection_top_macros.svh]
// Assertion macros for the depth back-projection checker.
`ifndef DEPTH_PIXEL_BACK_PROJECTION_TOP_MACROS_SVH
`define DEPTH_PIXEL_BACK_PROJECTION_TOP_MACROS_SVH

// Implication checked at every rising clock edge outside reset.
`define DPBP_ASSERT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("dpbp assertion failed");

// Condition that must never be seen outside reset.
`define DPBP_ASSERT_NEVER(label, clk, rst_n, cond) \
  `DPBP_ASSERT(label, clk, rst_n, 1'b1, !(cond))

`endif

[hw/rtl/dpbp_pkg.sv]
// Types, constants and helpers for the depth pixel back-projection block.
package dpbp_pkg;

  localparam int unsigned RAW_W   = 16;
  localparam int unsigned PIX_W   = 12;
  localparam int unsigned DIM_W   = 13;
  localparam int unsigned CTR_W   = 16;
  localparam int unsigned INV_W   = 32;
  localparam int unsigned RANGE_W = 23;
  localparam int unsigned COORD_W = 32;
  localparam int unsigned MAG_W   = 16;

  localparam int unsigned APB_ADDR_W = 5;
  localparam int unsigned APB_DATA_W = 32;

  // range = (raw*2^16 + 327) / 655 via reciprocal estimate plus correction
  localparam int unsigned RECIP_W   = 23;
  localparam logic [RECIP_W-1:0] RECIP_655 = 23'd6557201;  // floor(2^32/655)
  localparam int unsigned EST_W     = RAW_W + RECIP_W;     // 39
  localparam int unsigned NUM_W     = RAW_W + 16;          // 32
  localparam int unsigned REM_W     = 11;
  localparam logic [9:0]  COUNTS_PER_M = 10'd655;
  localparam logic [9:0]  HALF_COUNT   = 10'd327;

  // lateral product widths
  localparam int unsigned PROD_W    = MAG_W + RANGE_W;     // 39
  localparam int unsigned HI_W      = PROD_W - 32;         // 7
  localparam int unsigned SUM_W     = PROD_W + INV_W;      // 71
  localparam int unsigned RND_SHIFT = 36;
  localparam int unsigned LMAG_W    = SUM_W - RND_SHIFT;   // 35

  // pipeline depth
  localparam int unsigned RANGE_LAT = 3;
  localparam int unsigned LAT_LAT   = 4;
  localparam int unsigned PIPE_LAT  = 1 + RANGE_LAT + LAT_LAT;

  // register reset values
  localparam logic [DIM_W-1:0] RST_FRAME_WIDTH  = 13'd640;
  localparam logic [DIM_W-1:0] RST_FRAME_HEIGHT = 13'd480;
  localparam logic [CTR_W-1:0] RST_CENTER_COL   = 16'd5120;
  localparam logic [CTR_W-1:0] RST_CENTER_ROW   = 16'd3840;
  localparam logic [INV_W-1:0] RST_INV_FOCAL    = 32'd7158278;

  typedef enum logic [2:0] {
    REG_FRAME_WIDTH  = 3'd0,
    REG_FRAME_HEIGHT = 3'd1,
    REG_CENTER_COL   = 3'd2,
    REG_CENTER_ROW   = 3'd3,
    REG_INV_FOCAL_COL = 3'd4,
    REG_INV_FOCAL_ROW = 3'd5
  } reg_idx_e;

  typedef struct packed {
    logic [DIM_W-1:0] frame_width;
    logic [DIM_W-1:0] frame_height;
    logic [CTR_W-1:0] center_col_q4;
    logic [CTR_W-1:0] center_row_q4;
    logic [INV_W-1:0] inv_focal_col;
    logic [INV_W-1:0] inv_focal_row;
  } cfg_t;

  typedef struct packed {
    logic             neg;
    logic [MAG_W-1:0] mag;
  } offset_t;

  // Negate and clamp; neg_off means the pixel lies before the center.
  function automatic logic [COORD_W-1:0] lateral_sat(input logic neg_off,
                                                     input logic [LMAG_W-1:0] mag);
    logic [COORD_W-1:0] lim;
    if (neg_off) begin
      lim = (mag > LMAG_W'(32'h7FFF_FFFF)) ? 32'h7FFF_FFFF : mag[COORD_W-1:0];
      return lim;
    end else begin
      lim = (mag > LMAG_W'(32'h8000_0000)) ? 32'h8000_0000 : mag[COORD_W-1:0];
      return COORD_W'(0) - lim;
    end
  endfunction

endpackage

[hw/rtl/dpbp_cfg.sv]
// APB register file holding the camera configuration.
module dpbp_cfg import dpbp_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready,
  output cfg_t                  cfg_o
);

  cfg_t     cfg_q;
  reg_idx_e idx;
  logic     wr_en;

  assign idx    = reg_idx_e'(paddr[APB_ADDR_W-1:2]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.frame_width   <= RST_FRAME_WIDTH;
      cfg_q.frame_height  <= RST_FRAME_HEIGHT;
      cfg_q.center_col_q4 <= RST_CENTER_COL;
      cfg_q.center_row_q4 <= RST_CENTER_ROW;
      cfg_q.inv_focal_col <= RST_INV_FOCAL;
      cfg_q.inv_focal_row <= RST_INV_FOCAL;
    end else if (wr_en) begin
      case (idx)
        REG_FRAME_WIDTH:   cfg_q.frame_width   <= pwdata[DIM_W-1:0];
        REG_FRAME_HEIGHT:  cfg_q.frame_height  <= pwdata[DIM_W-1:0];
        REG_CENTER_COL:    cfg_q.center_col_q4 <= pwdata[CTR_W-1:0];
        REG_CENTER_ROW:    cfg_q.center_row_q4 <= pwdata[CTR_W-1:0];
        REG_INV_FOCAL_COL: cfg_q.inv_focal_col <= pwdata[INV_W-1:0];
        REG_INV_FOCAL_ROW: cfg_q.inv_focal_row <= pwdata[INV_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_FRAME_WIDTH:   prdata = APB_DATA_W'(cfg_q.frame_width);
      REG_FRAME_HEIGHT:  prdata = APB_DATA_W'(cfg_q.frame_height);
      REG_CENTER_COL:    prdata = APB_DATA_W'(cfg_q.center_col_q4);
      REG_CENTER_ROW:    prdata = APB_DATA_W'(cfg_q.center_row_q4);
      REG_INV_FOCAL_COL: prdata = APB_DATA_W'(cfg_q.inv_focal_col);
      REG_INV_FOCAL_ROW: prdata = APB_DATA_W'(cfg_q.inv_focal_row);
      default:           prdata = '0;
    endcase
  end

endmodule

[hw/rtl/dpbp_range.sv]
// Three-stage divide of the raw depth by 655 counts per meter, rounded.
module dpbp_range import dpbp_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  input  logic [RAW_W-1:0]   raw_i,
  output logic               valid_o,
  output logic [RANGE_W-1:0] range_o
);

  logic [2:0]         vld_q;
  logic [RAW_W-1:0]   raw2_q;
  logic [EST_W-1:0]   est2_q;
  logic [RANGE_W-1:0] qe3_q;
  logic [REM_W-1:0]   rem3_q;
  logic [RANGE_W-1:0] range4_q;

  logic [NUM_W-1:0]   num_d;
  logic [NUM_W:0]     back_d;
  logic [NUM_W:0]     rem_d;
  logic [RANGE_W-1:0] qe_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[1:0], valid_i};
    end
  end

  // estimate is low by at most two, so the remainder stays below 3*655
  assign qe_d   = est2_q[EST_W-1:16];
  assign num_d  = {raw2_q, 16'd0} + NUM_W'(HALF_COUNT);
  assign back_d = (NUM_W+1)'(qe_d) * (NUM_W+1)'(COUNTS_PER_M);
  assign rem_d  = (NUM_W+1)'(num_d) - back_d;

  always_ff @(posedge clk_i) begin
    est2_q   <= EST_W'(raw_i) * EST_W'(RECIP_655);
    raw2_q   <= raw_i;
    qe3_q    <= qe_d;
    rem3_q   <= rem_d[REM_W-1:0];
    range4_q <= qe3_q
              + RANGE_W'(rem3_q >= REM_W'(COUNTS_PER_M))
              + RANGE_W'(rem3_q >= REM_W'(2 * COUNTS_PER_M));
  end

  assign valid_o = vld_q[2];
  assign range_o = range4_q;

endmodule

[hw/rtl/dpbp_lateral.sv]
// Four-stage lateral coordinate: offset * range * (1/f), rounded and clamped.
module dpbp_lateral import dpbp_pkg::*; (
  input  logic               clk_i,
  input  offset_t            off_i,
  input  logic [RANGE_W-1:0] range_i,
  input  logic [INV_W-1:0]   inv_i,
  output logic [COORD_W-1:0] coord_o
);

  offset_t            off_dly_q [RANGE_LAT];
  logic [PROD_W-1:0]  prod_q;
  logic [63:0]        lo_q;
  logic [PROD_W-1:0]  hi_q;
  logic [LMAG_W-1:0]  mag_q;
  logic               neg5_q, neg6_q, neg7_q;
  logic [COORD_W-1:0] coord_q;
  logic [SUM_W-1:0]   sum_d;

  // offset waits here while the range is being divided
  always_ff @(posedge clk_i) begin
    off_dly_q[0] <= off_i;
    for (int i = 1; i < RANGE_LAT; i++) begin
      off_dly_q[i] <= off_dly_q[i-1];
    end
  end

  // round half up on the magnitude, then drop 36 fraction bits
  assign sum_d = {hi_q, 32'd0} + SUM_W'(lo_q) + (SUM_W'(1) << (RND_SHIFT - 1));

  always_ff @(posedge clk_i) begin
    prod_q  <= PROD_W'(off_dly_q[RANGE_LAT-1].mag) * PROD_W'(range_i);
    neg5_q  <= off_dly_q[RANGE_LAT-1].neg;
    lo_q    <= 64'(prod_q[31:0]) * 64'(inv_i);
    hi_q    <= PROD_W'(prod_q[PROD_W-1:32]) * PROD_W'(inv_i);
    neg6_q  <= neg5_q;
    mag_q   <= sum_d[SUM_W-1:RND_SHIFT];
    neg7_q  <= neg6_q;
    coord_q <= lateral_sat(neg7_q, mag_q);
  end

  assign coord_o = coord_q;

endmodule

[hw/rtl/depth_pixel_back_projection_top.sv]
// Top level of the depth pixel back-projection pipeline.
// Takes one depth pixel per clock and, for each kept pixel, pulses point_valid_o
// for one cycle with the 3D point; dropped pixels (border, or raw depth of 0 or 1)
// give no pulse. busy never rises, so a pixel may enter every cycle; each pixel
// passes the input register, the three-stage divide by 655 and the four-stage
// multiply/round/clamp of the lateral units. The receiver cannot stall and must
// take each result in its strobe cycle. Write the APB registers only while no
// pixel is in flight.
module depth_pixel_back_projection_top import dpbp_pkg::*; #(
  parameter int unsigned BORDER  = 10,
  parameter int unsigned MAX_DIM = 4096
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start,
  output logic                  busy,
  input  logic [RAW_W-1:0]      depth_raw_i,
  input  logic [PIX_W-1:0]      pixel_row_i,
  input  logic [PIX_W-1:0]      pixel_col_i,
  output logic                  point_valid_o,
  output logic [RANGE_W-1:0]    point_forward_o,
  output logic [COORD_W-1:0]    point_left_o,
  output logic [COORD_W-1:0]    point_up_o,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready
);

  localparam int unsigned CMP_W = 15;
  localparam logic [CMP_W-1:0] MAX_DIM_C = CMP_W'(MAX_DIM);
  localparam logic [CMP_W-1:0] BORDER_C  = CMP_W'(BORDER);

  cfg_t               cfg;
  logic               accept;
  logic               keep;
  logic               v1_q;
  logic [RAW_W-1:0]   raw1_q;
  offset_t            offc1_q, offr1_q;
  logic               rng_vld;
  logic [RANGE_W-1:0] rng;
  logic               vout_q [LAT_LAT];
  logic [RANGE_W-1:0] fwd_q  [LAT_LAT];

  function automatic logic in_frame(input logic [PIX_W-1:0] pix,
                                    input logic [DIM_W-1:0] dim);
    logic [CMP_W-1:0] dim_ext;
    logic [CMP_W-1:0] dim_c;
    logic [CMP_W-1:0] pos;
    dim_ext = CMP_W'(dim);
    dim_c   = (dim_ext > MAX_DIM_C) ? MAX_DIM_C : dim_ext;
    pos     = CMP_W'(pix);
    return (pos >= BORDER_C) && ((pos + BORDER_C) < dim_c);
  endfunction

  function automatic offset_t pix_offset(input logic [PIX_W-1:0] pix,
                                         input logic [CTR_W-1:0] center);
    logic [CTR_W:0] diff;
    logic [CTR_W:0] neg_diff;
    offset_t        o;
    diff     = {1'b0, pix, 4'd0} - {1'b0, center};
    neg_diff = (CTR_W+1)'(0) - diff;
    o.neg    = diff[CTR_W];
    o.mag    = o.neg ? neg_diff[MAG_W-1:0] : diff[MAG_W-1:0];
    return o;
  endfunction

  dpbp_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  assign busy   = 1'b0;
  assign accept = start && !busy;
  assign keep   = in_frame(pixel_row_i, cfg.frame_height)
               && in_frame(pixel_col_i, cfg.frame_width)
               && (depth_raw_i > RAW_W'(1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else begin
      v1_q <= accept && keep;
    end
  end

  always_ff @(posedge clk_i) begin
    raw1_q  <= depth_raw_i;
    offc1_q <= pix_offset(pixel_col_i, cfg.center_col_q4);
    offr1_q <= pix_offset(pixel_row_i, cfg.center_row_q4);
  end

  dpbp_range u_range (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (v1_q),
    .raw_i   (raw1_q),
    .valid_o (rng_vld),
    .range_o (rng)
  );

  dpbp_lateral u_lat_col (
    .clk_i   (clk_i),
    .off_i   (offc1_q),
    .range_i (rng),
    .inv_i   (cfg.inv_focal_col),
    .coord_o (point_left_o)
  );

  dpbp_lateral u_lat_row (
    .clk_i   (clk_i),
    .off_i   (offr1_q),
    .range_i (rng),
    .inv_i   (cfg.inv_focal_row),
    .coord_o (point_up_o)
  );

  // forward range and strobe ride alongside the lateral stages
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < LAT_LAT; i++) begin
        vout_q[i] <= 1'b0;
      end
    end else begin
      vout_q[0] <= rng_vld;
      for (int i = 1; i < LAT_LAT; i++) begin
        vout_q[i] <= vout_q[i-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    fwd_q[0] <= rng;
    for (int i = 1; i < LAT_LAT; i++) begin
      fwd_q[i] <= fwd_q[i-1];
    end
  end

  assign point_valid_o   = vout_q[LAT_LAT-1];
  assign point_forward_o = fwd_q[LAT_LAT-1];

endmodule

[hw/rtl/dpbp_checker.sv]
// Port-level checks for the back-projection top level, bound to it.
`include "depth_pixel_back_projection_top_macros.svh"

module dpbp_checker import dpbp_pkg::*; (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               start,
  input logic               busy,
  input logic [RAW_W-1:0]   depth_raw_i,
  input logic               point_valid_o,
  input logic [RANGE_W-1:0] point_forward_o
);

  logic        beat;
  logic        low_beat;
  logic [33:0] raw_q16;
  logic [33:0] raw_hi;
  logic [33:0] fwd_x655;
  logic [33:0] fwd_hi;

  assign beat     = start && !busy;
  assign low_beat = beat && (depth_raw_i <= RAW_W'(1));
  assign raw_q16  = {2'b00, depth_raw_i, 16'd0};
  assign raw_hi   = raw_q16 + 34'(HALF_COUNT);
  assign fwd_x655 = 34'(point_forward_o) * 34'(COUNTS_PER_M);
  assign fwd_hi   = fwd_x655 + 34'(HALF_COUNT);

  `DPBP_ASSERT(result_follows_beat, clk_i, rst_ni, point_valid_o, $past(beat, PIPE_LAT))
  `DPBP_ASSERT_NEVER(low_depth_dropped, clk_i, rst_ni, point_valid_o && $past(low_beat, PIPE_LAT))
  `DPBP_ASSERT(forward_not_low, clk_i, rst_ni, point_valid_o, fwd_hi >= $past(raw_q16, PIPE_LAT))
  `DPBP_ASSERT(forward_not_high, clk_i, rst_ni, point_valid_o, fwd_x655 <= $past(raw_hi, PIPE_LAT))

endmodule

bind depth_pixel_back_projection_top dpbp_checker u_dpbp_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .start           (start),
  .busy            (busy),
  .depth_raw_i     (depth_raw_i),
  .point_valid_o   (point_valid_o),
  .point_forward_o (point_forward_o)
);

[tb/tb_depth_pixel_back_projection_top.sv]
// Self-checking testbench for the depth pixel back-projection top level.
`timescale 1ns / 1ps

module tb_depth_pixel_back_projection_top;
  import dpbp_pkg::*;

  localparam int BORDER  = 10;
  localparam int MAX_DIM = 4096;
  localparam int LIMIT   = 200000;

  localparam logic [39:0] COUNTS_PER_METER = 40'd655;
  localparam logic [39:0] HALF_METER_COUNT = 40'd327;

  // addresses past the register file; writes there must change nothing
  localparam logic [2:0] REG_UNMAPPED_LO = 3'd6;
  localparam logic [2:0] REG_UNMAPPED_HI = 3'd7;

  typedef struct packed {
    logic [RAW_W-1:0] raw;
    logic [PIX_W-1:0] row;
    logic [PIX_W-1:0] col;
  } pixel_t;

  typedef struct packed {
    logic [RANGE_W-1:0] fwd;
    logic [COORD_W-1:0] left;
    logic [COORD_W-1:0] up;
  } point_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  start = 1'b0;
  logic                  busy;
  logic [RAW_W-1:0]      depth_raw_i = '0;
  logic [PIX_W-1:0]      pixel_row_i = '0;
  logic [PIX_W-1:0]      pixel_col_i = '0;
  logic                  point_valid_o;
  logic [RANGE_W-1:0]    point_forward_o;
  logic [COORD_W-1:0]    point_left_o;
  logic [COORD_W-1:0]    point_up_o;
  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [APB_ADDR_W-1:0] paddr = '0;
  logic [APB_DATA_W-1:0] pwdata = '0;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  pixel_t pixel_q[$];
  point_t expected_points[$];
  cfg_t   cam_cfg;
  int     gap_pct = 22;
  int     mismatches = 0;
  int     cycle_cnt = 0;

  depth_pixel_back_projection_top #(
    .BORDER (BORDER),
    .MAX_DIM(MAX_DIM)
  ) DUT (.*);

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("MISMATCH %s: got %h want %h", what, got, want);
    mismatches++;
  endtask

  function automatic bit in_interior(input logic [PIX_W-1:0] pos,
                                     input logic [DIM_W-1:0] dim_reg);
    int dim;
    dim = (dim_reg > MAX_DIM) ? MAX_DIM : int'(dim_reg);
    return int'(pos) >= BORDER && int'(pos) < dim - BORDER;
  endfunction

  // -(pix*16 - center) * range * inv / 2^36, magnitude rounded half up, clamped
  function automatic logic [COORD_W-1:0] lateral_coord(input logic [PIX_W-1:0] pix,
                                                       input logic [CTR_W-1:0] center,
                                                       input logic [RANGE_W-1:0] rng,
                                                       input logic [INV_W-1:0] inv);
    logic [15:0] pix_q4;
    logic        before_center;
    logic [15:0] off;
    logic [71:0] prod;
    logic [35:0] mag;
    pix_q4 = {pix, 4'b0000};
    before_center = pix_q4 < center;
    off = before_center ? center - pix_q4 : pix_q4 - center;
    prod = 72'(off) * 72'(rng) * 72'(inv) + (72'd1 << 35);
    mag = prod[71:36];
    if (mag == '0)
      return '0;
    if (before_center)
      return (mag > 36'h7FFF_FFFF) ? 32'h7FFF_FFFF : mag[31:0];
    return 32'd0 - ((mag > 36'h8000_0000) ? 32'h8000_0000 : mag[31:0]);
  endfunction

  function automatic bit project_pixel(input pixel_t px, output point_t pt);
    logic [39:0] rng;
    pt = '0;
    if (!in_interior(px.row, cam_cfg.frame_height) || !in_interior(px.col, cam_cfg.frame_width))
      return 1'b0;
    if (px.raw <= 16'd1)
      return 1'b0;
    rng = ({24'd0, px.raw} << 16) + HALF_METER_COUNT;
    rng = rng / COUNTS_PER_METER;
    pt.fwd  = rng[RANGE_W-1:0];
    pt.left = lateral_coord(px.col, cam_cfg.center_col_q4, pt.fwd, cam_cfg.inv_focal_col);
    pt.up   = lateral_coord(px.row, cam_cfg.center_row_q4, pt.fwd, cam_cfg.inv_focal_row);
    return 1'b1;
  endfunction

  // edges of the usable area get a large share; the rest mostly lands inside
  function automatic logic [PIX_W-1:0] pick_coord(input logic [DIM_W-1:0] dim_reg);
    int d;
    int v;
    d = (dim_reg > MAX_DIM) ? MAX_DIM : int'(dim_reg);
    case ($urandom_range(9))
      0: v = $urandom_range(4095);
      1: v = BORDER - 1;
      2: v = BORDER;
      3: v = d - BORDER - 1;
      4: v = d - BORDER;
      default: v = (d > 2 * BORDER) ? $urandom_range(d - BORDER - 1, BORDER)
                                    : $urandom_range(4095);
    endcase
    if (v < 0) v = 0;
    if (v > 4095) v = 4095;
    return v[PIX_W-1:0];
  endfunction

  function automatic logic [RAW_W-1:0] pick_depth();
    logic [31:0] r;
    case ($urandom_range(9))
      0: r = $urandom_range(3);
      1: r = 32'hFFFF - $urandom_range(1);
      default: r = $urandom;
    endcase
    return r[RAW_W-1:0];
  endfunction

  // register value with random bits above its width
  function automatic logic [31:0] pad_noise(input int unsigned width, input logic [31:0] v);
    logic [31:0] m;
    m = (width >= 32) ? 32'hFFFF_FFFF : ((32'd1 << width) - 32'd1);
    return ($urandom & ~m) | (v & m);
  endfunction

  task automatic queue_pixel(input logic [RAW_W-1:0] raw, input int row, input int col);
    pixel_t px;
    px.raw  = raw;
    px.row  = row[PIX_W-1:0];
    px.col  = col[PIX_W-1:0];
    pixel_q = {pixel_q, px};
  endtask

  task automatic queue_random(input int n);
    pixel_t px;
    for (int k = 0; k < n; k++) begin
      px.raw = pick_depth();
      px.row = pick_coord(cam_cfg.frame_height);
      px.col = pick_coord(cam_cfg.frame_width);
      pixel_q = {pixel_q, px};
    end
  endtask

  // dropped pixels leave no expectation, so wait out the pipe as well
  task automatic drain_pipeline();
    do @(negedge clk_i);
    while (pixel_q.size() != 0 || start || expected_points.size() != 0);
    repeat (PIPE_LAT + 2) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] data);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i);
    while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_FRAME_WIDTH:   cam_cfg.frame_width   = data[DIM_W-1:0];
      REG_FRAME_HEIGHT:  cam_cfg.frame_height  = data[DIM_W-1:0];
      REG_CENTER_COL:    cam_cfg.center_col_q4 = data[CTR_W-1:0];
      REG_CENTER_ROW:    cam_cfg.center_row_q4 = data[CTR_W-1:0];
      REG_INV_FOCAL_COL: cam_cfg.inv_focal_col = data[INV_W-1:0];
      REG_INV_FOCAL_ROW: cam_cfg.inv_focal_row = data[INV_W-1:0];
      default: ;
    endcase
  endtask

  // pixel driver: predicts each beat as it is taken, then offers the next one
  always @(posedge clk_i) begin : drive_pixels
    pixel_t nxt;
    point_t pt;
    if (rst_ni && start && !busy) begin
      if (project_pixel('{raw: depth_raw_i, row: pixel_row_i, col: pixel_col_i}, pt))
        expected_points = {expected_points, pt};
    end
    if (!rst_ni) begin
      start <= 1'b0;
    end else if (!start || !busy) begin
      if (pixel_q.size() != 0 && $urandom_range(99) >= gap_pct) begin
        nxt = pixel_q.pop_front();
        start       <= 1'b1;
        depth_raw_i <= nxt.raw;
        pixel_row_i <= nxt.row;
        pixel_col_i <= nxt.col;
      end else begin
        start       <= 1'b0;
        depth_raw_i <= RAW_W'($urandom);
        pixel_row_i <= PIX_W'($urandom);
        pixel_col_i <= PIX_W'($urandom);
      end
    end
  end

  always @(posedge clk_i) begin : check_points
    point_t want;
    if (rst_ni && point_valid_o) begin
      if (expected_points.size() == 0) begin
        report_mismatch("unexpected point, forward", 32'(point_forward_o), '0);
      end else begin
        want = expected_points.pop_front();
        if (point_forward_o !== want.fwd)
          report_mismatch("point_forward", 32'(point_forward_o), 32'(want.fwd));
        if (point_left_o !== want.left)
          report_mismatch("point_left", point_left_o, want.left);
        if (point_up_o !== want.up)
          report_mismatch("point_up", point_up_o, want.up);
      end
    end
  end

  initial begin
    int w;
    int h;
    cam_cfg = '{frame_width: RST_FRAME_WIDTH, frame_height: RST_FRAME_HEIGHT,
                center_col_q4: RST_CENTER_COL, center_row_q4: RST_CENTER_ROW,
                inv_focal_col: RST_INV_FOCAL, inv_focal_row: RST_INV_FOCAL};
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset settings: principal point at the frame center, border edges, tiny depths
    queue_pixel(16'd2, 240, 320);
    queue_pixel(16'd0, 240, 320);
    queue_pixel(16'd1, 240, 320);
    queue_pixel(16'hFFFF, 240, 320);
    queue_pixel(16'hFFFF, 10, 10);
    queue_pixel(16'hFFFF, 469, 629);
    queue_pixel(16'hFFFF, 9, 320);
    queue_pixel(16'hFFFF, 240, 9);
    queue_pixel(16'hFFFF, 470, 320);
    queue_pixel(16'hFFFF, 240, 630);
    queue_pixel(16'hFFFF, 4095, 4095);
    queue_pixel(16'd0, 0, 0);
    queue_pixel(16'd300, 100, 500);
    queue_pixel(16'd12345, 400, 50);
    queue_pixel(16'd2, 10, 629);
    queue_random(120);
    drain_pipeline();

    // largest frame (width above the clamp), widest reciprocals: lateral clamps
    write_reg(REG_FRAME_WIDTH, 32'hFFFF_FFFF);
    write_reg(REG_FRAME_HEIGHT, pad_noise(DIM_W, 32'd4096));
    write_reg(REG_CENTER_COL, 32'd0);
    write_reg(REG_CENTER_ROW, 32'hFFFF_FFFF);
    write_reg(REG_INV_FOCAL_COL, 32'hFFFF_FFFF);
    write_reg(REG_INV_FOCAL_ROW, 32'hFFFF_FFFF);
    gap_pct = 0;
    queue_pixel(16'hFFFF, 4085, 4085);
    queue_pixel(16'hFFFF, 10, 10);
    queue_pixel(16'hFFFF, 10, 4085);
    queue_pixel(16'd2, 4085, 10);
    queue_random(120);
    drain_pipeline();

    gap_pct = 22;
    write_reg(REG_CENTER_COL, 32'h0000_FFFF);
    write_reg(REG_CENTER_ROW, pad_noise(CTR_W, 32'd0));
    queue_random(60);
    drain_pipeline();

    // zero reciprocal
    write_reg(REG_FRAME_WIDTH, pad_noise(DIM_W, 32'd640));
    write_reg(REG_FRAME_HEIGHT, pad_noise(DIM_W, 32'd480));
    write_reg(REG_CENTER_COL, $urandom);
    write_reg(REG_CENTER_ROW, $urandom);
    write_reg(REG_INV_FOCAL_COL, 32'd0);
    write_reg(REG_INV_FOCAL_ROW, 32'd0);
    queue_random(60);
    drain_pipeline();

    // frame with no interior; unmapped addresses must be ignored
    write_reg(REG_FRAME_WIDTH, pad_noise(DIM_W, 32'd20));
    write_reg(REG_FRAME_HEIGHT, pad_noise(DIM_W, 32'd0));
    write_reg(REG_UNMAPPED_LO, $urandom);
    write_reg(REG_UNMAPPED_HI, $urandom);
    write_reg(REG_INV_FOCAL_COL, $urandom);
    write_reg(REG_INV_FOCAL_ROW, $urandom);
    queue_random(30);
    drain_pipeline();

    // smallest frame: a single interior pixel
    write_reg(REG_FRAME_WIDTH, pad_noise(DIM_W, 32'd21));
    write_reg(REG_FRAME_HEIGHT, pad_noise(DIM_W, 32'd21));
    queue_random(30);
    drain_pipeline();

    for (int k = 0; k < 4; k++) begin
      w = ($urandom_range(7) == 0) ? 8191 : $urandom_range(4096, 21);
      h = ($urandom_range(7) == 0) ? 8191 : $urandom_range(4096, 21);
      write_reg(REG_FRAME_WIDTH, pad_noise(DIM_W, w));
      write_reg(REG_FRAME_HEIGHT, pad_noise(DIM_W, h));
      write_reg(REG_CENTER_COL, $urandom);
      write_reg(REG_CENTER_ROW, $urandom);
      write_reg(REG_INV_FOCAL_COL, (k % 2 == 0) ? $urandom : $urandom_range(1 << 24, 1));
      write_reg(REG_INV_FOCAL_ROW, (k % 2 == 0) ? $urandom_range(1 << 24, 1) : $urandom);
      queue_random(50);
      drain_pipeline();
    end

    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
